>>> rtl/tlvef_pkg.sv
// Package for the TLV element finder: request/result payload types,
// parser phase encoding and status codes. No dependencies.
package tlvef_pkg;

    localparam int unsigned HeaderBytes = 4;
    localparam int unsigned PosWidth    = 17;

    typedef enum logic [3:0] {
        PH_HEADER   = 4'b0001,
        PH_VALUE    = 4'b0010,
        PH_DONE     = 4'b0100,
        PH_OVERLONG = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_ABSENT    = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } tlvef_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_length;
        logic [15:0] value_offset;
    } tlvef_res_t;

endpackage

>>> rtl/tlv_element_finder_unit.sv
// TLV element finder top level: byte-wide parser with input and result registers.
// Depends on tlvef_pkg for payload types, phase and status codes.
//
// Usage:
//   Bytes of a TLV block enter on the request channel (in_valid/in_stall/in_req),
//   one byte per request, with last_byte set on the final byte of the block.
//   Each element is a 16-bit big-endian tag, a 16-bit big-endian length and
//   that many value bytes. cfg_we/cfg_data load the tag to search for; write
//   it only while no request is in flight.
//   The result channel (out_valid/out_stall/out_res) carries at most one result
//   per block: found (with length and value offset) on the byte that completes
//   the matching element, else absent or malformed on the last byte.
//   Throughput is one byte per cycle while the receiver does not stall, set by the
//   combinational update of the parse state (position, header and length counters).
//   An accepted request passes through the input register, then the result register.
//   When the receiver stalls, the pending result holds in the result register
//   and the input register holds one byte; in_stall rises once both are full.
//   Reset clears the parse state, the valid flags and the wanted tag (zero).
module tlv_element_finder_unit
    import tlvef_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  tlvef_req_t  in_req,
    output logic        out_valid,
    input  logic        out_stall,
    output tlvef_res_t  out_res
);

    logic [15:0]         wanted_tag_reg;
    logic                in_valid_reg;
    tlvef_req_t          in_data_reg;
    logic                out_valid_reg;
    tlvef_res_t          out_res_reg;

    phase_t              phase_reg, phase_next;
    logic [1:0]          header_count_reg, header_count_next;
    logic [15:0]         current_tag_reg, current_tag_next;
    logic [15:0]         current_length_reg, current_length_next;
    logic [15:0]         bytes_remaining_reg, bytes_remaining_next;
    logic [PosWidth-1:0] byte_position_reg, byte_position_next;
    logic                match_pending_reg, match_pending_next;

    logic                advance;
    logic                emit;
    tlvef_res_t          res;
    logic                found;
    logic [15:0]         f_len;
    logic [15:0]         f_off;
    logic [15:0]         pos_plus1;
    logic [15:0]         rem_dec;
    logic                at_limit;
    logic [7:0]          b;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign b         = in_data_reg.data_byte;
    assign pos_plus1 = byte_position_reg[15:0] + 16'd1;
    assign rem_dec   = bytes_remaining_reg - 16'd1;
    // byte index 65535 or beyond
    assign at_limit  = byte_position_reg[16] || (&byte_position_reg[15:0]);

    always_comb
    begin
        phase_next           = phase_reg;
        header_count_next    = header_count_reg;
        current_tag_next     = current_tag_reg;
        current_length_next  = current_length_reg;
        bytes_remaining_next = bytes_remaining_reg;
        match_pending_next   = match_pending_reg;
        byte_position_next   = byte_position_reg[16] ? byte_position_reg
                                                     : byte_position_reg + 1'b1;
        found = 1'b0;
        f_len = 16'd0;
        f_off = 16'd0;
        emit  = 1'b0;
        res   = '0;

        if (phase_reg != PH_DONE && at_limit)
        begin
            phase_next = PH_OVERLONG;
        end

        if (phase_next == PH_HEADER)
        begin
            case (header_count_reg)
                2'd0:    current_tag_next    = {b, 8'd0};
                2'd1:    current_tag_next    = {current_tag_reg[15:8], b};
                2'd2:    current_length_next = {b, 8'd0};
                default: current_length_next = {current_length_reg[15:8], b};
            endcase
            if (header_count_reg != 2'(HeaderBytes - 1))
            begin
                header_count_next = header_count_reg + 2'd1;
            end
            else
            begin
                header_count_next = 2'd0;
                if (current_length_next == 16'd0)
                begin
                    if (current_tag_next == wanted_tag_reg)
                    begin
                        found = 1'b1;
                        f_off = pos_plus1;
                    end
                end
                else
                begin
                    phase_next           = PH_VALUE;
                    bytes_remaining_next = current_length_next;
                    match_pending_next   = (current_tag_next == wanted_tag_reg);
                end
            end
        end
        else if (phase_next == PH_VALUE)
        begin
            bytes_remaining_next = rem_dec;
            if (rem_dec == 16'd0)
            begin
                if (match_pending_reg)
                begin
                    found = 1'b1;
                    f_len = current_length_reg;
                    f_off = pos_plus1 - current_length_reg;
                end
                match_pending_next = 1'b0;
                phase_next         = PH_HEADER;
            end
        end

        if (found)
        begin
            emit             = 1'b1;
            res.status       = ST_FOUND;
            res.found_length = f_len;
            res.value_offset = f_off;
            phase_next       = PH_DONE;
        end
        else if (in_data_reg.last_byte && phase_next != PH_DONE)
        begin
            emit = 1'b1;
            if (phase_next == PH_HEADER && header_count_next == 2'd0)
            begin
                res.status = ST_ABSENT;
            end
            else
            begin
                res.status = ST_MALFORMED;
            end
        end

        // end of block: start the next one from scratch
        if (in_data_reg.last_byte)
        begin
            phase_next           = PH_HEADER;
            header_count_next    = 2'd0;
            current_tag_next     = 16'd0;
            current_length_next  = 16'd0;
            bytes_remaining_next = 16'd0;
            byte_position_next   = '0;
            match_pending_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wanted_tag_reg      <= 16'd0;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            phase_reg           <= PH_HEADER;
            header_count_reg    <= 2'd0;
            current_tag_reg     <= 16'd0;
            current_length_reg  <= 16'd0;
            bytes_remaining_reg <= 16'd0;
            byte_position_reg   <= '0;
            match_pending_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wanted_tag_reg <= cfg_data;
            end
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg       <= emit;
                phase_reg           <= phase_next;
                header_count_reg    <= header_count_next;
                current_tag_reg     <= current_tag_next;
                current_length_reg  <= current_length_next;
                bytes_remaining_reg <= bytes_remaining_next;
                byte_position_reg   <= byte_position_next;
                match_pending_reg   <= match_pending_next;
            end
            else if (!out_stall)
            begin
                // result taken, nothing new behind it
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            in_data_reg <= in_req;
        end
        if (advance && emit)
        begin
            out_res_reg <= res;
        end
    end

endmodule
